// ===== hw/rtl/tkpd_pkg.sv =====
`default_nettype none

package tkpd_pkg;

  localparam int NumChannels = 9;
  localparam int AvgLog2     = 5;

  localparam int ChanW   = 4;
  localparam int SampleW = 10;
  localparam int LevelW  = 10;
  localparam int SumW    = 15;
  localparam int KeyW    = 5;
  localparam int SumIdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  localparam logic [SumW-1:0]    SumMax      = {SumW{1'b1}};
  localparam logic [LevelW-1:0]  LevelMax    = {LevelW{1'b1}};
  localparam logic [LevelW-1:0]  ThreshReset = LevelW'(50);
  localparam logic [ChanW-1:0]   LastChan    = ChanW'(NumChannels - 1);
  localparam logic [ChanW:0]     ChanLimit   = (ChanW + 1)'(NumChannels);

  localparam logic [1:0] OpcodeClear = 2'd0;
  localparam logic [1:0] OpcodeCal   = 2'd1;
  localparam logic [1:0] OpcodeScan  = 2'd2;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam int KeyTableLen = 20;
  localparam logic [KeyW-1:0] KeyNone = KeyW'(20);

  // channel pair masks by key code: 0-15 hex, AD, OK, PLUS, MU
  localparam logic [15:0] KeyPairMask [KeyTableLen] = '{
    16'h0048, 16'h0104, 16'h000C, 16'h0005,
    16'h0110, 16'h0018, 16'h0011, 16'h0120,
    16'h0028, 16'h0021, 16'h0140, 16'h0041,
    16'h0006, 16'h0012, 16'h0022, 16'h0042,
    16'h0084, 16'h0090, 16'h00A0, 16'h00C0
  };

  typedef enum logic [1:0] {
    OpClear,
    OpCal,
    OpScan
  } op_kind_e;

  typedef struct packed {
    op_kind_e               kind;
    logic [ChanW-1:0]       chan;
    logic [SampleW-1:0]     sample;
  } q_entry_t;

  function automatic logic [KeyW-1:0] key_of_pair(input logic [ChanW-1:0] a,
                                                  input logic [ChanW-1:0] b);
    logic [15:0]     mask;
    logic [KeyW-1:0] key;
    mask = (16'd1 << a) | (16'd1 << b);
    key  = KeyNone;
    for (int k = KeyTableLen - 1; k >= 0; k--) begin
      if (KeyPairMask[k] == mask) begin
        key = KeyW'(k);
      end
    end
    return key;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tkpd_front.sv =====
`default_nettype none

module tkpd_front (
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [tkpd_pkg::ChanW-1:0]    channel_i,
  input  wire logic [tkpd_pkg::SampleW-1:0]  sample_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output tkpd_pkg::q_entry_t                 q_entry_o
);

  logic     chan_ok;
  logic     keep;
  tkpd_pkg::op_kind_e kind;

  assign chan_ok = ({1'b0, channel_i} < tkpd_pkg::ChanLimit);

  always_comb begin
    kind = tkpd_pkg::OpClear;
    keep = 1'b0;
    case (opcode_i)
      tkpd_pkg::OpcodeClear: begin
        kind = tkpd_pkg::OpClear;
        keep = 1'b1;
      end
      tkpd_pkg::OpcodeCal: begin
        kind = tkpd_pkg::OpCal;
        keep = chan_ok;
      end
      tkpd_pkg::OpcodeScan: begin
        kind = tkpd_pkg::OpScan;
        keep = chan_ok;
      end
      default: begin
        kind = tkpd_pkg::OpClear;
        keep = 1'b0;
      end
    endcase
  end

  // dropped beats are still taken so the channel never hangs
  assign in_ready_o       = !q_full_i;
  assign q_push_o         = in_valid_i && !q_full_i && keep;
  assign q_entry_o.kind   = kind;
  assign q_entry_o.chan   = channel_i;
  assign q_entry_o.sample = sample_i;

endmodule

`default_nettype wire

// ===== hw/rtl/tkpd_queue.sv =====
`default_nettype none

module tkpd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  tkpd_pkg::q_entry_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               head_valid_o,
  output tkpd_pkg::q_entry_t head_o
);

  tkpd_pkg::q_entry_t mem_q [tkpd_pkg::QueueDepth];
  logic [tkpd_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [tkpd_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [tkpd_pkg::QueuePtrW:0]   count_q, count_d;
  logic do_push, do_pop;

  assign full_o       = (count_q == (tkpd_pkg::QueuePtrW + 1)'(tkpd_pkg::QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tkpd_back.sv =====
`default_nettype none

module tkpd_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [tkpd_pkg::LevelW-1:0]   threshold_i,
  input  wire logic                          head_valid_i,
  input  tkpd_pkg::q_entry_t                 head_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [tkpd_pkg::KeyW-1:0]          key_code_o,
  output logic [tkpd_pkg::ChanW-1:0]         top_channel_o,
  output logic [tkpd_pkg::ChanW-1:0]         second_channel_o
);

  localparam int SumW   = tkpd_pkg::SumW;
  localparam int LevelW = tkpd_pkg::LevelW;
  localparam int ChanW  = tkpd_pkg::ChanW;

  logic [SumW-1:0] sum_q [tkpd_pkg::NumChannels];
  logic [tkpd_pkg::SumIdxW-1:0] idx;
  logic [SumW-1:0] cur_sum, base, diff;
  logic [SumW:0]   sum_add;
  logic [SumW-1:0] sum_sat;
  logic [LevelW-1:0] lvl_sat, lvl;

  logic en;

  // level stage
  logic              a_valid_q, a_valid_d;
  logic [LevelW-1:0] a_lvl_q;
  logic [ChanW-1:0]  a_chan_q;

  // running top two
  logic [LevelW-1:0] best_lvl_q, best_lvl_d, run_lvl_q, run_lvl_d;
  logic [ChanW-1:0]  best_chan_q, best_chan_d, run_chan_q, run_chan_d;
  logic              run_seen_q, run_seen_d;

  logic                        out_valid_q, out_valid_d;
  logic [tkpd_pkg::KeyW-1:0]   key_q;
  logic [ChanW-1:0]            top_q, second_q;
  logic                        emit;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && head_valid_i;
  assign idx   = head_i.chan[tkpd_pkg::SumIdxW-1:0];

  always_comb begin
    cur_sum = sum_q[idx];
    sum_add = {1'b0, cur_sum} + (SumW + 1)'(head_i.sample);
    sum_sat = sum_add[SumW] ? tkpd_pkg::SumMax : sum_add[SumW-1:0];
    base    = cur_sum >> tkpd_pkg::AvgLog2;
    diff    = base - SumW'(head_i.sample);
    lvl_sat = (|diff[SumW-1:LevelW]) ? tkpd_pkg::LevelMax : diff[LevelW-1:0];
    if (SumW'(head_i.sample) >= base || lvl_sat < threshold_i) begin
      lvl = '0;
    end else begin
      lvl = lvl_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tkpd_pkg::NumChannels; i++) begin
        sum_q[i] <= '0;
      end
    end else if (pop_o) begin
      case (head_i.kind)
        tkpd_pkg::OpClear: begin
          for (int i = 0; i < tkpd_pkg::NumChannels; i++) begin
            sum_q[i] <= '0;
          end
        end
        tkpd_pkg::OpCal: begin
          sum_q[idx] <= sum_sat;
        end
        default: begin
        end
      endcase
    end
  end

  assign a_valid_d = en ? (pop_o && head_i.kind == tkpd_pkg::OpScan) : a_valid_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_lvl_q  <= lvl;
      a_chan_q <= head_i.chan;
    end
  end

  always_comb begin
    best_lvl_d  = best_lvl_q;
    best_chan_d = best_chan_q;
    run_lvl_d   = run_lvl_q;
    run_chan_d  = run_chan_q;
    run_seen_d  = run_seen_q;
    if (a_chan_q == '0) begin
      best_lvl_d  = a_lvl_q;
      best_chan_d = '0;
      run_seen_d  = 1'b0;
    end else if (a_lvl_q > best_lvl_q) begin
      run_lvl_d   = best_lvl_q;
      run_chan_d  = best_chan_q;
      run_seen_d  = 1'b1;
      best_lvl_d  = a_lvl_q;
      best_chan_d = a_chan_q;
    end else if (!run_seen_q || a_lvl_q > run_lvl_q) begin
      run_lvl_d  = a_lvl_q;
      run_chan_d = a_chan_q;
      run_seen_d = 1'b1;
    end
  end

  assign emit        = a_valid_q && (a_chan_q == tkpd_pkg::LastChan);
  assign out_valid_d = en ? emit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      best_lvl_q  <= '0;
      best_chan_q <= '0;
      run_lvl_q   <= '0;
      run_chan_q  <= '0;
      run_seen_q  <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
      if (en && a_valid_q) begin
        best_lvl_q  <= best_lvl_d;
        best_chan_q <= best_chan_d;
        run_lvl_q   <= run_lvl_d;
        run_chan_q  <= run_chan_d;
        run_seen_q  <= run_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && emit) begin
      key_q    <= tkpd_pkg::key_of_pair(best_chan_d, run_chan_d);
      top_q    <= best_chan_d;
      second_q <= run_chan_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign key_code_o       = key_q;
  assign top_channel_o    = top_q;
  assign second_channel_o = second_q;

endmodule

`default_nettype wire

// ===== hw/rtl/touch_keypad_pair_decoder_unit.sv =====
// Channel  Handshake                Beat
// in       in_valid_i/in_ready_o    opcode_i, channel_i, sample_i
// out      out_valid_o/out_ready_i  key_code_o, top_channel_o, second_channel_o
// cfg      cfg_valid_i/cfg_ready_o  cfg_data_i (touch threshold)
//
// One input beat per cycle while the queue is not full; a result passes from its
// scan beat through the queue, level stage and tracker into the output register.
// Output stalls freeze the back end; the 4-entry queue keeps the input side taking
// beats until it fills. Reset clears the queue, baseline sums, tracker and threshold
// (to 50). Opcode 3 and out-of-range channels on cal or scan beats are taken and dropped.
`default_nettype none

module touch_keypad_pair_decoder_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [tkpd_pkg::ChanW-1:0]    channel_i,
  input  wire logic [tkpd_pkg::SampleW-1:0]  sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [tkpd_pkg::KeyW-1:0]          key_code_o,
  output logic [tkpd_pkg::ChanW-1:0]         top_channel_o,
  output logic [tkpd_pkg::ChanW-1:0]         second_channel_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [tkpd_pkg::LevelW-1:0]   cfg_data_i
);

  logic [tkpd_pkg::LevelW-1:0] thresh_q;
  logic                        q_full, q_push, q_pop, head_valid;
  tkpd_pkg::q_entry_t          q_entry, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= tkpd_pkg::ThreshReset;
    end else if (cfg_valid_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  tkpd_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .channel_i  (channel_i),
    .sample_i   (sample_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  tkpd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_data_i  (q_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  tkpd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .threshold_i      (thresh_q),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .key_code_o       (key_code_o),
    .top_channel_o    (top_channel_o),
    .second_channel_o (second_channel_o)
  );

endmodule

`default_nettype wire
